@@ design/ntia_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ntia_pkg
// Shared constants, codes and types for the nearest track id assigner.
// ---------------------------------------------------------------------------
package ntia_pkg;

  localparam int MAX_TRACKS = 16;
  localparam int COORD_BITS = 12;

  localparam int IDX_W   = $clog2(MAX_TRACKS);
  localparam int CNT_W   = $clog2(MAX_TRACKS + 1);
  localparam int ID_W    = 5;
  localparam int CAND_W  = (CNT_W > ID_W) ? CNT_W : ID_W;
  localparam int FACE_W  = 12;
  localparam int RAD_W   = 12;
  localparam int THR_W   = 8;
  localparam int LOST_W  = 8;
  localparam int CONS_W  = 9;
  localparam int STAT_W  = 3;
  localparam int DIN_W   = (COORD_BITS > RAD_W) ? COORD_BITS : RAD_W;
  localparam int DIST_W  = 2 * DIN_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT = 2'd2;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 8'd10;
  localparam logic [RAD_W-1:0]  RADIUS_RST     = 12'd50;
  localparam logic [LOST_W-1:0] LOST_LIMIT_RST = 8'd10;

  localparam logic [CONS_W-1:0] CONS_MAX = '1;
  localparam logic [LOST_W-1:0] LOST_MAX = '1;

  localparam logic [STAT_W-1:0] STATUS_CONSOL  = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_MATCHED = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_NEW     = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_CLEARED = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [LOST_W-1:0]     lost;
  } ntia_entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    ntia_entry_t       entry;
  } ntia_wr_t;

endpackage : ntia_pkg
`default_nettype wire

@@ design/ntia_dist.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ntia_dist
// Shared squared-distance unit: registered (ax-bx)^2 + (ay-by)^2.
// ---------------------------------------------------------------------------
module ntia_dist (
  input  wire logic                       clk,
  input  wire logic [ntia_pkg::DIN_W-1:0] a_x,
  input  wire logic [ntia_pkg::DIN_W-1:0] a_y,
  input  wire logic [ntia_pkg::DIN_W-1:0] b_x,
  input  wire logic [ntia_pkg::DIN_W-1:0] b_y,
  output logic      [ntia_pkg::DIST_W-1:0] dist_q
);
  import ntia_pkg::*;

  logic [DIN_W-1:0]   dx;
  logic [DIN_W-1:0]   dy;
  logic [2*DIN_W-1:0] sx;
  logic [2*DIN_W-1:0] sy;

  always_comb begin
    dx = (a_x > b_x) ? (a_x - b_x) : (b_x - a_x);
    dy = (a_y > b_y) ? (a_y - b_y) : (b_y - a_y);
    sx = dx * dx;
    sy = dy * dy;
  end

  always_ff @(posedge clk) begin
    dist_q <= DIST_W'(sx) + DIST_W'(sy);
  end

endmodule : ntia_dist
`default_nettype wire

@@ design/ntia_table.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ntia_table
// Track table storage: one read index, one write port.
// ---------------------------------------------------------------------------
module ntia_table (
  input  wire logic                      clk,
  input  wire logic [ntia_pkg::IDX_W-1:0] rd_idx,
  output ntia_pkg::ntia_entry_t           rd_entry,
  input  wire ntia_pkg::ntia_wr_t         wr
);
  import ntia_pkg::*;

  ntia_entry_t entries_r [MAX_TRACKS];

  assign rd_entry = entries_r[rd_idx];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries_r[wr.idx] <= wr.entry;
    end
  end

endmodule : ntia_table
`default_nettype wire

@@ design/nearest_track_id_assigner_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// nearest_track_id_assigner_unit
// Nearest-neighbor face track association with a sequencer around one
// shared squared-distance unit.
// ---------------------------------------------------------------------------
// Sequence: a clear or consolidating item ends in the check state; a matched
//   item also runs radius, scan and decide, and a new track item then compacts.
// Throughput: one item at a time; busy drops in the cycle the result is out,
//   so the next item can be accepted in that same cycle.
// The result is on the out_ ports for one cycle; the receiver cannot stall.
// Reset: configuration to defaults, table empty, consolidation count zero.
// ---------------------------------------------------------------------------
module nearest_track_id_assigner_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_command,
  input  wire logic                            in_first_in_frame,
  input  wire logic [ntia_pkg::FACE_W-1:0]     in_face_x,
  input  wire logic [ntia_pkg::FACE_W-1:0]     in_face_y,
  output logic                                 out_strobe,
  output logic      [ntia_pkg::STAT_W-1:0]     out_status,
  output logic      [ntia_pkg::ID_W-1:0]       out_track_id,
  output logic      [ntia_pkg::ID_W-1:0]       out_track_count,
  input  wire logic                            cfg_we,
  input  wire logic [ntia_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ntia_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ntia_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_RADIUS  = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_DECIDE  = 3'd4;
  localparam logic [2:0] S_COMPACT = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic                  cmd_r;
  logic                  first_r;
  logic [COORD_BITS-1:0] fx_r, fy_r;
  logic [THR_W-1:0]      thr_r;
  logic [RAD_W-1:0]      radius_r;
  logic [LOST_W-1:0]     limit_r;
  logic [CONS_W-1:0]     cons_r, cons_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]      w_r, w_nxt;
  logic [CAND_W-1:0]     cand_r, cand_nxt;
  logic                  found_r, found_nxt;
  logic [DIST_W-1:0]     best_r, best_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0]     r2_r, r2_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pidx_r, pidx_nxt;

  logic                  strobe_r, strobe_nxt;
  logic [STAT_W-1:0]     status_r, status_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [ID_W-1:0]       count_r, count_nxt;

  logic                  accept;
  logic [IDX_W-1:0]      rd_idx;
  ntia_entry_t           rd_entry;
  ntia_wr_t              wr;
  logic [DIN_W-1:0]      a_x, a_y, b_x, b_y;
  logic [DIST_W-1:0]     dist_q;
  logic [LOST_W-1:0]     lost_inc;
  logic [CAND_W-1:0]     cand_new;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_track_id    = id_r;
  assign out_track_count = count_r;

  ntia_table u_table (
    .clk      (clk),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  ntia_dist u_dist (
    .clk    (clk),
    .a_x    (a_x),
    .a_y    (a_y),
    .b_x    (b_x),
    .b_y    (b_y),
    .dist_q (dist_q)
  );

  always_comb begin
    rd_idx = (state_r == S_DECIDE) ? best_idx_r : k_r[IDX_W-1:0];
    if (state_r == S_CHECK) begin
      a_x = DIN_W'(radius_r);
      a_y = '0;
      b_x = '0;
      b_y = '0;
    end else begin
      a_x = DIN_W'(rd_entry.x);
      a_y = DIN_W'(rd_entry.y);
      b_x = DIN_W'(fx_r);
      b_y = DIN_W'(fy_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cons_nxt     = cons_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    w_nxt        = w_r;
    cand_nxt     = cand_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    r2_nxt       = r2_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    id_nxt       = id_r;
    count_nxt    = count_r;
    wr           = '0;
    lost_inc     = (rd_entry.lost == LOST_MAX) ? rd_entry.lost : rd_entry.lost + 1'b1;
    cand_new     = (cand_r == CAND_W'(rd_entry.id)) ? cand_r + 1'b1 : cand_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cmd_r) begin
          cons_nxt   = '0;
          cnt_nxt    = '0;
          strobe_nxt = 1'b1;
          status_nxt = STATUS_CLEARED;
          id_nxt     = '0;
          count_nxt  = '0;
          state_nxt  = S_IDLE;
        end else begin
          if (first_r && (cons_r != CONS_MAX)) begin
            cons_nxt = cons_r + 1'b1;
          end
          if (cons_nxt > CONS_W'(thr_r)) begin
            state_nxt = S_RADIUS;
          end else begin
            strobe_nxt = 1'b1;
            status_nxt = STATUS_CONSOL;
            id_nxt     = '0;
            count_nxt  = ID_W'(cnt_r);
            state_nxt  = S_IDLE;
          end
        end
      end
      S_RADIUS: begin
        r2_nxt    = dist_q;
        k_nxt     = '0;
        found_nxt = 1'b0;
        pend_nxt  = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (pend_r && (!found_r || (dist_q < best_r))) begin
          found_nxt    = 1'b1;
          best_nxt     = dist_q;
          best_idx_nxt = pidx_r;
        end
        if (k_r < cnt_r) begin
          pend_nxt = 1'b1;
          pidx_nxt = k_r[IDX_W-1:0];
          k_nxt    = k_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (found_r && (best_r < r2_r)) begin
          wr.en         = 1'b1;
          wr.idx        = best_idx_r;
          wr.entry.id   = rd_entry.id;
          wr.entry.x    = fx_r;
          wr.entry.y    = fy_r;
          wr.entry.lost = rd_entry.lost;
          strobe_nxt    = 1'b1;
          status_nxt    = STATUS_MATCHED;
          id_nxt        = rd_entry.id;
          count_nxt     = ID_W'(cnt_r);
          state_nxt     = S_IDLE;
        end else begin
          k_nxt     = '0;
          w_nxt     = '0;
          cand_nxt  = '0;
          state_nxt = S_COMPACT;
        end
      end
      S_COMPACT: begin
        if (k_r < cnt_r) begin
          cand_nxt = cand_new;
          if (lost_inc <= limit_r) begin
            wr.en         = 1'b1;
            wr.idx        = w_r[IDX_W-1:0];
            wr.entry.id   = rd_entry.id;
            wr.entry.x    = rd_entry.x;
            wr.entry.y    = rd_entry.y;
            wr.entry.lost = lost_inc;
            w_nxt         = w_r + 1'b1;
          end
          k_nxt = k_r + 1'b1;
        end else begin
          strobe_nxt = 1'b1;
          id_nxt     = ID_W'(cand_r);
          if (w_r < CNT_W'(MAX_TRACKS)) begin
            wr.en         = 1'b1;
            wr.idx        = w_r[IDX_W-1:0];
            wr.entry.id   = ID_W'(cand_r);
            wr.entry.x    = fx_r;
            wr.entry.y    = fy_r;
            wr.entry.lost = '0;
            cnt_nxt       = w_r + 1'b1;
            status_nxt    = STATUS_NEW;
          end else begin
            cnt_nxt    = w_r;
            status_nxt = STATUS_FULL;
          end
          count_nxt = ID_W'(cnt_nxt);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cons_r   <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
      thr_r    <= THRESHOLD_RST;
      radius_r <= RADIUS_RST;
      limit_r  <= LOST_LIMIT_RST;
    end else begin
      state_r  <= state_nxt;
      cons_r   <= cons_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
      pend_r   <= pend_nxt;
      found_r  <= found_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD:  thr_r    <= cfg_data[THR_W-1:0];
          CFG_RADIUS:     radius_r <= cfg_data[RAD_W-1:0];
          CFG_LOST_LIMIT: limit_r  <= cfg_data[LOST_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      first_r <= in_first_in_frame;
      fx_r    <= in_face_x[COORD_BITS-1:0];
      fy_r    <= in_face_y[COORD_BITS-1:0];
    end
    k_r        <= k_nxt;
    w_r        <= w_nxt;
    cand_r     <= cand_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    r2_r       <= r2_nxt;
    pidx_r     <= pidx_nxt;
    status_r   <= status_nxt;
    id_r       <= id_nxt;
    count_r    <= count_nxt;
  end

endmodule : nearest_track_id_assigner_unit
`default_nettype wire

@@ dv/nearest_track_id_assigner_unit_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// nearest_track_id_assigner_unit_tb
// Drives face detections and empty-frame marks through the start/busy port
// and predicts status, track id and table size with a local copy of the
// track table. Checks every out_strobe result against the prediction.
// Covers directed corners (full table, zero and maximum radius, counter and
// lost-count saturation), then random frames built around moving faces.
// ---------------------------------------------------------------------------
module nearest_track_id_assigner_unit_tb;
  import ntia_pkg::*;

  localparam logic CMD_FACE      = 1'b0;
  localparam logic CMD_NO_FACES  = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int   COORD_TOP     = (1 << FACE_W) - 1;

  typedef struct packed {
    logic              command;
    logic              first_in_frame;
    logic [FACE_W-1:0] face_x;
    logic [FACE_W-1:0] face_y;
  } face_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   track_id;
    logic [ID_W-1:0]   track_count;
  } track_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_command = 1'b0;
  logic                  in_first_in_frame = 1'b0;
  logic [FACE_W-1:0]     in_face_x = '0;
  logic [FACE_W-1:0]     in_face_y = '0;
  logic                  out_strobe;
  logic [STAT_W-1:0]     out_status;
  logic [ID_W-1:0]       out_track_id;
  logic [ID_W-1:0]       out_track_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  face_item_t    faces_to_send[$];
  track_result_t track_results_due[$];
  int            errors = 0;
  int            burst_left = 1;
  int            gap_left = 0;

  logic [ID_W-1:0]       trk_id   [MAX_TRACKS];
  logic [COORD_BITS-1:0] trk_x    [MAX_TRACKS];
  logic [COORD_BITS-1:0] trk_y    [MAX_TRACKS];
  logic [LOST_W-1:0]     trk_lost [MAX_TRACKS];
  int                    n_tracks;
  int                    frames_seen;
  logic [THR_W-1:0]      thr_cfg;
  logic [RAD_W-1:0]      radius_cfg;
  logic [LOST_W-1:0]     lost_cfg;

  nearest_track_id_assigner_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_first_in_frame(in_first_in_frame),
    .in_face_x       (in_face_x),
    .in_face_y       (in_face_y),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_track_id    (out_track_id),
    .out_track_count (out_track_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic track_result_t associate_face(face_item_t it);
    track_result_t         r;
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
    int                    k;
    int                    best;
    int                    dx;
    int                    dy;
    int                    w;
    int                    cand;
    bit                    found;
    longint                d;
    longint                best_d;
    longint                r2;
    r      = '0;
    fx     = it.face_x[COORD_BITS-1:0];
    fy     = it.face_y[COORD_BITS-1:0];
    best   = 0;
    best_d = 0;
    found  = 1'b0;
    if (it.command == CMD_NO_FACES) begin
      frames_seen = 0;
      n_tracks    = 0;
      r.status    = STATUS_CLEARED;
    end else begin
      if (it.first_in_frame && frames_seen < int'(CONS_MAX))
        frames_seen++;
      if (frames_seen > int'(thr_cfg)) begin
        r2 = longint'(radius_cfg) * longint'(radius_cfg);
        for (k = 0; k < n_tracks; k++) begin
          dx = int'(trk_x[k]) - int'(fx);
          dy = int'(trk_y[k]) - int'(fy);
          d  = longint'(dx) * dx + longint'(dy) * dy;
          if (!found || d < best_d) begin
            found  = 1'b1;
            best_d = d;
            best   = k;
          end
        end
        if (found && best_d < r2) begin
          r.track_id  = trk_id[best];
          trk_x[best] = fx;
          trk_y[best] = fy;
          r.status    = STATUS_MATCHED;
        end else begin
          w    = 0;
          cand = 0;
          for (k = 0; k < n_tracks; k++) begin
            if (cand == int'(trk_id[k]))
              cand++;
            if (trk_lost[k] != LOST_MAX)
              trk_lost[k] = trk_lost[k] + 1'b1;
            if (trk_lost[k] <= lost_cfg) begin
              trk_id[w]   = trk_id[k];
              trk_x[w]    = trk_x[k];
              trk_y[w]    = trk_y[k];
              trk_lost[w] = trk_lost[k];
              w++;
            end
          end
          n_tracks   = w;
          r.track_id = cand[ID_W-1:0];
          if (w < MAX_TRACKS) begin
            trk_id[w]   = cand[ID_W-1:0];
            trk_x[w]    = fx;
            trk_y[w]    = fy;
            trk_lost[w] = '0;
            n_tracks    = w + 1;
            r.status    = STATUS_NEW;
          end else begin
            r.status = STATUS_FULL;
          end
        end
      end
    end
    r.track_count = n_tracks[ID_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : drive
    face_item_t nxt;
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (start && !busy)
        track_results_due = {track_results_due,
                             associate_face({in_command, in_first_in_frame,
                                             in_face_x, in_face_y})};
      if (!(start && busy)) begin
        if (gap_left == 0 && faces_to_send.size() != 0) begin
          nxt = faces_to_send.pop_front();
          start             <= 1'b1;
          in_command        <= nxt.command;
          in_first_in_frame <= nxt.first_in_frame;
          in_face_x         <= nxt.face_x;
          in_face_y         <= nxt.face_y;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start             <= 1'b0;
          in_command        <= 1'($urandom);
          in_first_in_frame <= 1'($urandom);
          in_face_x         <= FACE_W'($urandom);
          in_face_y         <= FACE_W'($urandom);
          if (gap_left != 0)
            gap_left <= gap_left - 1;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("t=%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    track_result_t want;
    if (rst_n && out_strobe) begin
      if (track_results_due.size() == 0) begin
        $display("t=%0t unexpected result: expected none, actual status %0d id %0d count %0d",
                 $time, out_status, out_track_id, out_track_count);
        errors++;
      end else begin
        want = track_results_due.pop_front();
        check_field("status", want.status, out_status);
        check_field("track_id", want.track_id, out_track_id);
        check_field("track_count", want.track_count, out_track_count);
      end
    end
  end

  task automatic add_item(input logic cmd, input logic first, input int x, input int y);
    faces_to_send = {faces_to_send, face_item_t'({cmd, first, FACE_W'(x), FACE_W'(y)})};
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_THRESHOLD:  thr_cfg    = data[THR_W-1:0];
      CFG_RADIUS:     radius_cfg = data[RAD_W-1:0];
      CFG_LOST_LIMIT: lost_cfg   = data[LOST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int thr, input int radius, input int lost);
    write_reg(CFG_THRESHOLD, {4'($urandom), 8'(thr)});
    write_reg(CFG_RADIUS, 12'(radius));
    write_reg(CFG_LOST_LIMIT, {4'($urandom), 8'(lost)});
    write_reg(CFG_UNUSED, 12'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (faces_to_send.size() != 0 || start || busy || track_results_due.size() != 0);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_TOP) ? COORD_TOP : v;
  endfunction

  initial begin : stimulus
    int   ph;
    int   n;
    int   nf;
    int   f;
    int   j;
    int   spread;
    int   sel;
    int   thr;
    int   radius;
    int   lost;
    int   px[6];
    int   py[6];
    logic first;

    thr_cfg     = THRESHOLD_RST;
    radius_cfg  = RADIUS_RST;
    lost_cfg    = LOST_LIMIT_RST;
    n_tracks    = 0;
    frames_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: clear, then faces still consolidating
    add_item(CMD_NO_FACES, 1'b1, COORD_TOP, COORD_TOP);
    add_item(CMD_FACE, 1'b1, 0, 0);
    add_item(CMD_FACE, 1'b0, COORD_TOP, COORD_TOP);
    wait_idle();

    // widest radius, removal on first miss
    configure(0, COORD_TOP, 0);
    add_item(CMD_FACE, 1'b1, COORD_TOP, COORD_TOP);
    add_item(CMD_FACE, 1'b0, COORD_TOP, 0);
    add_item(CMD_FACE, 1'b0, COORD_TOP, 1);
    wait_idle();

    // zero radius fills the table, then overflows
    configure(0, 0, 255);
    add_item(CMD_NO_FACES, 1'b0, 0, 0);
    add_item(CMD_FACE, 1'b1, 12'hAAA, 12'h555);
    repeat (16) add_item(CMD_FACE, 1'b0, 12'hAAA, 12'h555);
    wait_idle();

    // saturate frame counter and lost counts, then age out at limit 254
    configure(255, 0, 255);
    repeat (512) add_item(CMD_FACE, 1'b1, $urandom_range(0, COORD_TOP),
                          $urandom_range(0, COORD_TOP));
    wait_idle();
    configure(255, 0, 254);
    repeat (3) add_item(CMD_FACE, 1'b0, $urandom_range(0, COORD_TOP),
                        $urandom_range(0, COORD_TOP));
    wait_idle();

    for (ph = 0; ph < 3; ph++) begin
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      sel = $urandom_range(0, 7);
      radius = (sel == 0) ? 0 : (sel == 1) ? COORD_TOP : $urandom_range(8, 300);
      sel = $urandom_range(0, 7);
      lost = (sel == 0) ? 0 : (sel == 1) ? 254 : (sel == 2) ? 255 : $urandom_range(1, 12);
      configure(thr, radius, lost);
      for (j = 0; j < 6; j++) begin
        px[j] = $urandom_range(0, COORD_TOP);
        py[j] = $urandom_range(0, COORD_TOP);
      end
      n = 0;
      while (n < 12) begin
        if ($urandom_range(0, 99) < 8) begin
          add_item(CMD_NO_FACES, 1'($urandom), $urandom_range(0, COORD_TOP),
                   $urandom_range(0, COORD_TOP));
          n++;
        end else begin
          nf = $urandom_range(1, 4);
          for (f = 0; f < nf; f++) begin
            j      = $urandom_range(0, 5);
            spread = ($urandom_range(0, 4) == 0) ? 80 : 16;
            if ($urandom_range(0, 29) == 0) begin
              px[j] = $urandom_range(0, COORD_TOP);
              py[j] = $urandom_range(0, COORD_TOP);
            end
            px[j] = clamp_coord(px[j] + int'($urandom_range(0, 2 * spread)) - spread);
            py[j] = clamp_coord(py[j] + int'($urandom_range(0, 2 * spread)) - spread);
            first = (f == 0);
            if ($urandom_range(0, 19) == 0)
              first = ~first;
            if ($urandom_range(0, 9) == 0)
              add_item(CMD_FACE, first, $urandom_range(0, COORD_TOP),
                       $urandom_range(0, COORD_TOP));
            else
              add_item(CMD_FACE, first, px[j], py[j]);
          end
          n += nf;
        end
      end
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && track_results_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule : nearest_track_id_assigner_unit_tb
`default_nettype wire
